/* rtl/core/assert_macros.svh */
// Assertion helper macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/core/jst_pkg.sv */
// Package with shared types and constants of the JSON stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package jst_pkg;
  localparam int STACK_DEPTH = 64;
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_INIT, S_IDINIT, S_IDENT, S_COLON, S_VALUE, S_STRING, S_ESCAPE, S_AFTER,
    S_FINISH, S_INT, S_FLOAT, S_NULL, S_TRUE, S_FALSE
  } lex_state_t;

  localparam logic [1:0] K_BYTE = 2'd0;
  localparam logic [1:0] K_END = 2'd1;
  localparam logic [1:0] K_ERR = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  localparam logic [3:0] T_ARR_OPEN = 4'd1;
  localparam logic [3:0] T_OBJ_CLOSE = 4'd2;
  localparam logic [3:0] T_IDENT = 4'd4;
  localparam logic [3:0] T_STRING = 4'd5;
  localparam logic [3:0] T_INT = 4'd6;
  localparam logic [3:0] T_FLOAT = 4'd7;
  localparam logic [3:0] T_NULL = 4'd8;
  localparam logic [3:0] T_BOOL = 4'd9;

  localparam logic [3:0] E_INIT = 4'd0;
  localparam logic [3:0] E_IDQUOTE = 4'd1;
  localparam logic [3:0] E_IDCHAR = 4'd2;
  localparam logic [3:0] E_COLON = 4'd3;
  localparam logic [3:0] E_VALUE = 4'd4;
  localparam logic [3:0] E_ESCAPE = 4'd5;
  localparam logic [3:0] E_MISMATCH = 4'd6;
  localparam logic [3:0] E_AFTER = 4'd7;
  localparam logic [3:0] E_TRAIL = 4'd8;
  localparam logic [3:0] E_NUMBER = 4'd9;
  localparam logic [3:0] E_LITERAL = 4'd10;
  localparam logic [3:0] E_OVERFLOW = 4'd11;
  localparam logic [3:0] E_EOT = 4'd12;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] ttype;
    logic [7:0] data;
    logic [3:0] code;
  } rec_t;

  // Up to three records produced for one request, in order.
  typedef struct packed {
    logic [1:0] count;
    rec_t r0;
    rec_t r1;
    rec_t r2;
  } grp_t;

  function automatic logic is_skip(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  // Letter expected at a given position of a literal; zero past its end.
  function automatic logic [7:0] lit_char(input logic [1:0] li, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (li)
      2'd0: case (p) 3'd0: ch = "n"; 3'd1: ch = "u"; 3'd2: ch = "l"; 3'd3: ch = "l";
        default: ch = 8'h00; endcase
      2'd1: case (p) 3'd0: ch = "t"; 3'd1: ch = "r"; 3'd2: ch = "u"; 3'd3: ch = "e";
        default: ch = 8'h00; endcase
      default: case (p) 3'd0: ch = "f"; 3'd1: ch = "a"; 3'd2: ch = "l"; 3'd3: ch = "s";
        3'd4: ch = "e"; default: ch = 8'h00; endcase
    endcase
    return ch;
  endfunction

  // Escape translation; bit 8 marks a valid escape.
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      "n": r = {1'b1, 8'd10};
      "t": r = {1'b1, 8'd9};
      "b": r = {1'b1, 8'd8};
      "r": r = {1'b1, 8'd13};
      "a": r = {1'b1, 8'd7};
      "f": r = {1'b1, 8'd12};
      "v": r = {1'b1, 8'd11};
      8'h27, 8'h22, 8'h3f, 8'h5c: r = {1'b1, c};
      8'h00: r = {1'b1, 8'h00};
      default: r = 9'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/jst_front.sv */
// Front end: accepts requests, runs the lexer state and stack, groups records.
`timescale 1ns / 1ps
`default_nettype none
module jst_front (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  input  wire            cmd,
  input  wire [7:0]      in_byte,
  input  wire            q_full,
  output logic           in_stall,
  output logic           g_valid,
  output jst_pkg::grp_t  g
);
  import jst_pkg::*;

  lex_state_t        st, st_next;
  logic              stk [STACK_DEPTH];
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic [2:0]        lpos, lpos_next;
  logic              mo, mo_next;
  logic              err, err_next;
  logic              push_en;
  logic              push_bit;
  logic              top;
  rec_t              rs [3];
  logic [1:0]        n;
  logic              acc;

  assign in_stall = q_full;
  assign acc = in_valid && !q_full;

  // Lexer step for one request.
  always_comb begin
    logic [7:0] c;
    logic [1:0] li;
    logic [8:0] em;
    logic [3:0] nt;
    logic av;
    logic do_open;
    logic open_arr;
    st_next = st; lvl_next = lvl; lpos_next = lpos; mo_next = mo; err_next = err;
    push_en = 1'b0; push_bit = 1'b0;
    n = 2'd0;
    for (int k = 0; k < 3; k++) rs[k] = '0;
    c = in_byte;
    li = 2'd0; em = esc_map(c); nt = T_INT;
    av = 1'b0; do_open = 1'b0; open_arr = 1'b0;
    if (cmd) begin
      if (!err) begin
        rs[0].kind = (st == S_FINISH) ? K_DONE : K_ERR;
        rs[0].code = (st == S_FINISH) ? 4'd0 : E_EOT;
        n = 2'd1;
      end
      st_next = S_INIT; lvl_next = '0; lpos_next = '0; mo_next = 1'b0; err_next = 1'b0;
    end else if (!err) begin
      case (st)
        S_INIT: begin
          if (c == "{") do_open = 1'b1;
          else if (c == "[") begin do_open = 1'b1; open_arr = 1'b1; end
          else if (!is_skip(c)) begin rs[0].kind = K_ERR; rs[0].code = E_INIT; n = 2'd1; end
        end
        S_IDINIT: begin
          if (c == 8'h22) st_next = S_IDENT;
          else if (c == "}") av = 1'b1;
          else if (!is_skip(c)) begin rs[0].kind = K_ERR; rs[0].code = E_IDQUOTE; n = 2'd1; end
        end
        S_IDENT: begin
          if (c == 8'h22) begin
            rs[0].kind = K_END; rs[0].ttype = T_IDENT; n = 2'd1; st_next = S_COLON;
          end else if (is_alnum(c) || c == "_") begin
            rs[0].ttype = T_IDENT; rs[0].data = c; n = 2'd1;
          end else begin rs[0].kind = K_ERR; rs[0].code = E_IDCHAR; n = 2'd1; end
        end
        S_COLON: begin
          if (c == ":") st_next = S_VALUE;
          else if (!is_skip(c)) begin rs[0].kind = K_ERR; rs[0].code = E_COLON; n = 2'd1; end
        end
        S_VALUE: begin
          if (c == "{") do_open = 1'b1;
          else if (c == "[") begin do_open = 1'b1; open_arr = 1'b1; end
          else if (c == "]") av = 1'b1;
          else if (c == 8'h22) st_next = S_STRING;
          else if (c == "n" || c == "t" || c == "f") begin
            li = (c == "n") ? 2'd0 : (c == "t") ? 2'd1 : 2'd2;
            rs[0].ttype = (li == 2'd0) ? T_NULL : T_BOOL; rs[0].data = c; n = 2'd1;
            lpos_next = 3'd1;
            st_next = (li == 2'd0) ? S_NULL : (li == 2'd1) ? S_TRUE : S_FALSE;
          end else if (is_digit(c) || c == "-") begin
            rs[0].ttype = T_INT; rs[0].data = c; n = 2'd1;
            mo_next = (c == "-"); st_next = S_INT;
          end else if (!is_skip(c)) begin rs[0].kind = K_ERR; rs[0].code = E_VALUE; n = 2'd1; end
        end
        S_STRING: begin
          if (c == 8'h22) begin
            rs[0].kind = K_END; rs[0].ttype = T_STRING; n = 2'd1; st_next = S_AFTER;
          end else if (c == 8'h5c) st_next = S_ESCAPE;
          else begin rs[0].ttype = T_STRING; rs[0].data = c; n = 2'd1; end
        end
        S_ESCAPE: begin
          if (em[8]) begin
            rs[0].ttype = T_STRING; rs[0].data = em[7:0]; n = 2'd1; st_next = S_STRING;
          end else begin rs[0].kind = K_ERR; rs[0].code = E_ESCAPE; n = 2'd1; end
        end
        S_AFTER: av = 1'b1;
        S_INT, S_FLOAT: begin
          nt = (st == S_INT) ? T_INT : T_FLOAT;
          if (is_digit(c)) begin
            rs[0].ttype = nt; rs[0].data = c; n = 2'd1; mo_next = 1'b0;
          end else if (st == S_INT && mo) begin
            rs[0].kind = K_ERR; rs[0].code = E_NUMBER; n = 2'd1;
          end else if (st == S_INT && c == ".") begin
            rs[0].ttype = T_FLOAT; rs[0].data = c; n = 2'd1; st_next = S_FLOAT;
          end else if (is_skip(c) || c == "," || c == "}" || c == "]") begin
            rs[0].kind = K_END; rs[0].ttype = nt; n = 2'd1; st_next = S_AFTER;
            av = !is_skip(c);
          end else begin rs[0].kind = K_ERR; rs[0].code = E_NUMBER; n = 2'd1; end
        end
        S_NULL, S_TRUE, S_FALSE: begin
          li = (st == S_NULL) ? 2'd0 : (st == S_TRUE) ? 2'd1 : 2'd2;
          if (lit_char(li, lpos) == 8'h00 || c != lit_char(li, lpos)) begin
            rs[0].kind = K_ERR; rs[0].code = E_LITERAL; n = 2'd1;
          end else begin
            rs[0].ttype = (li == 2'd0) ? T_NULL : T_BOOL; rs[0].data = c; n = 2'd1;
            lpos_next = lpos + 3'd1;
            if (lit_char(li, lpos + 3'd1) == 8'h00) begin
              rs[1].kind = K_END; rs[1].ttype = rs[0].ttype; n = 2'd2;
              lpos_next = 3'd0; st_next = S_AFTER;
            end
          end
        end
        default: begin
          if (!is_skip(c)) begin rs[0].kind = K_ERR; rs[0].code = E_TRAIL; n = 2'd1; end
        end
      endcase
      // Bracket opening with push.
      if (do_open) begin
        if (lvl >= LVL_W'(STACK_DEPTH)) begin
          rs[0].kind = K_ERR; rs[0].code = E_OVERFLOW; n = 2'd1;
        end else begin
          push_en = 1'b1; push_bit = open_arr; lvl_next = lvl + LVL_W'(1);
          rs[0].ttype = {3'd0, open_arr}; rs[0].data = c;
          rs[1].kind = K_END; rs[1].ttype = {3'd0, open_arr}; n = 2'd2;
          st_next = open_arr ? S_VALUE : S_IDINIT;
        end
      end
      // Byte handled as following a value; appended after any earlier record.
      if (av && !is_skip(c)) begin
        if (c == ",") begin
          if (lvl == '0) begin rs[n].kind = K_ERR; rs[n].code = E_AFTER; n = n + 2'd1; end
          else st_next = top ? S_VALUE : S_IDINIT;
        end else if (c == "}" || c == "]") begin
          if (lvl == '0 || top != (c == "]")) begin
            rs[n].kind = K_ERR; rs[n].code = E_MISMATCH; n = n + 2'd1;
          end else begin
            lvl_next = lvl - LVL_W'(1);
            rs[n].ttype = T_OBJ_CLOSE + {3'd0, c == "]"}; rs[n].data = c;
            rs[n + 2'd1].kind = K_END; rs[n + 2'd1].ttype = rs[n].ttype;
            n = n + 2'd2;
            st_next = (lvl == LVL_W'(1)) ? S_FINISH : S_AFTER;
          end
        end else begin rs[n].kind = K_ERR; rs[n].code = E_AFTER; n = n + 2'd1; end
      end
      for (int k = 0; k < 3; k++)
        if (k < n && rs[k].kind == K_ERR) err_next = 1'b1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_INIT; lvl <= '0; lpos <= '0; mo <= 1'b0; err <= 1'b0;
    end else if (acc) begin
      st <= st_next; lvl <= lvl_next; lpos <= lpos_next; mo <= mo_next; err <= err_next;
    end
  end

  // Nesting stack.
  always_ff @(posedge clk) begin
    if (acc && push_en) stk[PTR_W'(lvl)] <= push_bit;
  end

  // Registered copy of the top stack entry for the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= 1'b0;
    end else if (acc) begin
      if (push_en) top <= push_bit;
      else if (lvl_next == '0) top <= 1'b0;
      else top <= stk[PTR_W'(lvl_next - LVL_W'(1))];
    end
  end

  assign g_valid = acc && (n != 2'd0);
  assign g.count = n;
  assign g.r0 = rs[0];
  assign g.r1 = rs[1];
  assign g.r2 = rs[2];
endmodule
`default_nettype wire

/* rtl/core/jst_back.sv */
// Back end: queue of record groups and serial delivery of records.
`timescale 1ns / 1ps
`default_nettype none
module jst_back (
  input  wire            clk,
  input  wire            rst,
  input  wire            g_valid,
  input  jst_pkg::grp_t  g,
  output logic           q_full,
  output logic           valid,
  input  wire            stall,
  output logic [1:0]     emit_kind,
  output logic [3:0]     token_type,
  output logic [7:0]     out_byte,
  output logic [3:0]     error_code,
  output logic           last
);
  import jst_pkg::*;

  localparam int QD = 4;
  grp_t        q [QD];
  logic [1:0]  wp, rp;
  logic [2:0]  cnt;
  logic [1:0]  sub;
  grp_t        h;
  rec_t        cur;
  logic        pop;
  logic        take;

  assign q_full = (cnt == 3'(QD));
  assign h = q[rp];
  assign valid = (cnt != 3'd0);
  assign cur = (sub == 2'd0) ? h.r0 : (sub == 2'd1) ? h.r1 : h.r2;
  assign last = (sub + 2'd1 == h.count);
  assign take = valid && !stall;
  assign pop = take && last;
  assign emit_kind = cur.kind;
  assign token_type = cur.ttype;
  assign out_byte = cur.data;
  assign error_code = cur.code;

  // Group storage.
  always_ff @(posedge clk) begin
    if (g_valid) q[wp] <= g;
  end

  // Pointers, fill count and record index.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; sub <= '0;
    end else begin
      if (g_valid) wp <= wp + 2'd1;
      if (pop) begin rp <= rp + 2'd1; sub <= '0; end
      else if (take) sub <= sub + 2'd1;
      cnt <= cnt + 3'(g_valid) - 3'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/json_stream_tokenizer_core.sv */
// Top level of the JSON stream tokenizer.
// channel | direction | handshake     | payload
// input   | in        | valid / stall | cmd, in_byte
// output  | out       | out_valid / out_stall | emit_kind, token_type, out_byte, error_code, last
// One request is accepted per cycle while the group queue has room.
// Each request yields up to three records, delivered one per cycle by the back end while out_stall is low.
// The group queue holds four requests; the record delivery port sets the sustained rate.
// Reset is synchronous and clears state, stack level and queue.
// Output stall only backs up the queue; input stalls once it is full.
`timescale 1ns / 1ps
`default_nettype none
module json_stream_tokenizer_core (
  input  wire        clk,
  input  wire        rst,
  input  wire        valid,
  output logic       stall,
  input  wire        cmd,
  input  wire [7:0]  in_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] emit_kind,
  output logic [3:0] token_type,
  output logic [7:0] out_byte,
  output logic [3:0] error_code,
  output logic       last
);
  import jst_pkg::*;

  grp_t g;
  logic g_valid;
  logic q_full;

  jst_front u_front (
    .clk(clk), .rst(rst), .in_valid(valid), .cmd(cmd), .in_byte(in_byte),
    .q_full(q_full), .in_stall(stall), .g_valid(g_valid), .g(g)
  );

  jst_back u_back (
    .clk(clk), .rst(rst), .g_valid(g_valid), .g(g), .q_full(q_full),
    .valid(out_valid), .stall(out_stall), .emit_kind(emit_kind),
    .token_type(token_type), .out_byte(out_byte), .error_code(error_code), .last(last)
  );
endmodule
`default_nettype wire

/* rtl/core/jst_checker.sv */
// Port-level checker for the tokenizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jst_checker (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_stall,
  input wire [1:0] emit_kind,
  input wire [3:0] token_type,
  input wire [7:0] out_byte,
  input wire [3:0] error_code,
  input wire       last
);
  import jst_pkg::*;

  `CHK_IMPLY(a_err_code, clk, rst, out_valid && emit_kind == K_ERR, error_code <= E_EOT, "bad code")
  `CHK_IMPLY(a_done_last, clk, rst, out_valid && emit_kind == K_DONE, last, "done not last")
  `CHK_IMPLY(a_type_rng, clk, rst, out_valid, token_type <= T_BOOL, "bad token type")
  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte), "hold")
endmodule

bind json_stream_tokenizer_core jst_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .emit_kind(emit_kind), .token_type(token_type), .out_byte(out_byte),
  .error_code(error_code), .last(last)
);
`default_nettype wire
